/* hdl/i2c_slave_register_window_core_macros.svh */
`ifndef I2C_SLAVE_REGISTER_WINDOW_CORE_MACROS_SVH
`define I2C_SLAVE_REGISTER_WINDOW_CORE_MACROS_SVH

`ifndef SYNTH
`define I2CW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define I2CW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define I2CW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/i2cw_pkg.sv */
`default_nettype none
package i2cw_pkg;

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int OFF_W  = 5;
    localparam int FLAG_W = 4;

    localparam int FLAG_READ  = 0;
    localparam int FLAG_WRITE = 1;
    localparam int FLAG_NACK  = 2;
    localparam int FLAG_ERROR = 3;

    localparam logic [NIB_W-1:0]  WIN_BASE        = 4'hF;
    localparam logic [BYTE_W-1:0] BYTE_OUT_RANGE  = 8'hFB;
    localparam logic [BYTE_W-1:0] BYTE_OTHER_BASE = 8'hAE;

    typedef enum logic [1:0] {
        SRC_NONE       = 2'd0,
        SRC_TABLE      = 2'd1,
        SRC_OUT_RANGE  = 2'd2,
        SRC_OTHER_BASE = 2'd3
    } t_byte_src;

    typedef struct packed {
        logic              addr_match;
        logic              dir_read;
        logic              tx_request;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              nack_event;
        logic              stop_event;
        logic              bus_error;
        logic              arb_lost;
        logic              overrun;
    } t_evt;

    typedef struct packed {
        t_byte_src         src;
        logic              dir_send;
        logic [FLAG_W-1:0] flags;
    } t_res_info;

endpackage
`default_nettype wire

/* hdl/i2cw_channels.sv */
`default_nettype none
interface i2cw_evt_if;
    import i2cw_pkg::*;

    logic              valid;
    logic              ready;
    logic              addr_match;
    logic              dir_read;
    logic              tx_request;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              nack_event;
    logic              stop_event;
    logic              bus_error;
    logic              arb_lost;
    logic              overrun;

    modport source (
        output valid, addr_match, dir_read, tx_request, rx_valid, rx_byte,
               nack_event, stop_event, bus_error, arb_lost, overrun,
        input  ready
    );
    modport sink (
        input  valid, addr_match, dir_read, tx_request, rx_valid, rx_byte,
               nack_event, stop_event, bus_error, arb_lost, overrun,
        output ready
    );
endinterface

interface i2cw_res_if;
    import i2cw_pkg::*;

    logic              valid;
    logic              ready;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              dir_send;
    logic              read_done;
    logic              write_done;
    logic              nack_seen;
    logic              error_seen;

    modport source (
        output valid, tx_valid, tx_byte, dir_send, read_done, write_done,
               nack_seen, error_seen,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, dir_send, read_done, write_done,
               nack_seen, error_seen,
        output ready
    );
endinterface
`default_nettype wire

/* hdl/i2cw_table_mem.sv */
`default_nettype none
module i2cw_table_mem #(
    parameter int TABLE_SIZE = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [IDX_W-1:0]           i_rd_idx,
    input  wire logic                       i_wr_en,
    input  wire logic [IDX_W-1:0]           i_wr_idx,
    input  wire logic [i2cw_pkg::BYTE_W-1:0] i_wr_data,
    output logic      [i2cw_pkg::BYTE_W-1:0] o_rd_data
);
    import i2cw_pkg::*;

    logic [BYTE_W-1:0]     r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_written;
    logic [BYTE_W-1:0]     r_rd_data;
    logic                  r_rd_ok;

    // read sees the contents before a write on the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_ok <= r_written[i_rd_idx];
            end
            if (i_wr_en) begin
                r_written[i_wr_idx] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;
endmodule
`default_nettype wire

/* hdl/i2cw_ctrl.sv */
`default_nettype none
`include "i2c_slave_register_window_core_macros.svh"
module i2cw_ctrl #(
    parameter int TABLE_SIZE = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_wdata,
    input  wire logic                        i_accept,
    input  wire i2cw_pkg::t_evt              i_evt,
    output i2cw_pkg::t_res_info              o_info,
    output logic                             o_rd_en,
    output logic      [IDX_W-1:0]            o_rd_idx,
    output logic                             o_wr_en,
    output logic      [IDX_W-1:0]            o_wr_idx,
    output logic      [i2cw_pkg::BYTE_W-1:0] o_wr_data
);
    import i2cw_pkg::*;

    localparam logic [OFF_W-1:0] TS_OFF = OFF_W'(TABLE_SIZE);

    logic              r_no_stretch;
    logic [NIB_W-1:0]  r_base, n_base;
    logic [OFF_W-1:0]  r_off, n_off;
    logic              r_first_seen, n_first_seen;
    logic              r_send_dir, n_send_dir;
    logic [FLAG_W-1:0] r_flags, n_flags;
    t_byte_src         src;
    logic [OFF_W-1:0]  rd_off;
    logic [OFF_W-1:0]  wr_off;
    logic              wr_hit;

    always_comb begin
        n_base       = r_base;
        n_off        = r_off;
        n_first_seen = r_first_seen;
        n_send_dir   = r_send_dir;
        n_flags      = r_flags;
        src          = SRC_NONE;
        rd_off       = r_off;
        wr_off       = r_off;
        wr_hit       = 1'b0;

        // preload on read address match while no_stretch is clear, no wrap
        if (i_evt.addr_match) begin
            if (i_evt.dir_read) begin
                n_send_dir = 1'b1;
                if (!r_no_stretch) begin
                    if (n_base != WIN_BASE) begin
                        src = SRC_OTHER_BASE;
                    end else if (n_off >= TS_OFF) begin
                        src = SRC_OUT_RANGE;
                    end else begin
                        src    = SRC_TABLE;
                        rd_off = n_off;
                        n_off  = n_off + OFF_W'(1);
                    end
                end
            end else begin
                n_send_dir = 1'b0;
            end
        end

        if (i_evt.tx_request) begin
            if (n_base != WIN_BASE) begin
                src = SRC_OTHER_BASE;
            end else if (n_off >= TS_OFF) begin
                src = SRC_OUT_RANGE;
            end else begin
                src    = SRC_TABLE;
                rd_off = n_off;
                n_off  = (n_off + OFF_W'(1) >= TS_OFF) ? '0 : n_off + OFF_W'(1);
            end
        end

        if (i_evt.rx_valid) begin
            if (n_first_seen) begin
                if (n_base == WIN_BASE && n_off < TS_OFF) begin
                    wr_hit = 1'b1;
                    wr_off = n_off;
                    n_off  = (n_off + OFF_W'(1) >= TS_OFF) ? '0 : n_off + OFF_W'(1);
                end
            end else begin
                n_base       = i_evt.rx_byte[BYTE_W-1:NIB_W];
                n_off        = OFF_W'(i_evt.rx_byte[NIB_W-1:0]);
                n_first_seen = 1'b1;
            end
        end

        if (i_evt.nack_event) begin
            n_first_seen         = 1'b0;
            n_flags[FLAG_NACK]   = 1'b1;
        end

        if (i_evt.stop_event) begin
            if (n_send_dir) begin
                n_send_dir         = 1'b0;
                n_flags[FLAG_READ] = 1'b1;
            end else begin
                n_flags[FLAG_WRITE] = 1'b1;
            end
            n_first_seen = 1'b0;
        end

        if (i_evt.bus_error || i_evt.arb_lost || i_evt.overrun) begin
            n_flags[FLAG_ERROR] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_stretch <= 1'b1;
            r_base       <= '0;
            r_off        <= '0;
            r_first_seen <= 1'b0;
            r_send_dir   <= 1'b0;
            r_flags      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_no_stretch <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_base       <= n_base;
                r_off        <= n_off;
                r_first_seen <= n_first_seen;
                r_send_dir   <= n_send_dir;
                r_flags      <= n_flags;
            end
        end
    end

    assign o_info.src      = src;
    assign o_info.dir_send = n_send_dir;
    assign o_info.flags    = n_flags;
    assign o_rd_en         = i_accept && (src == SRC_TABLE);
    assign o_rd_idx        = rd_off[IDX_W-1:0];
    assign o_wr_en         = i_accept && wr_hit;
    assign o_wr_idx        = wr_off[IDX_W-1:0];
    assign o_wr_data       = i_evt.rx_byte;

    `I2CW_ASSERT_NOW(a_table_read_in_window, i_clk, i_rst_n, o_rd_en, (r_base == WIN_BASE) && (rd_off < TS_OFF), "table read outside the window")
    `I2CW_ASSERT_NOW(a_table_write_in_range, i_clk, i_rst_n, o_wr_en, wr_off < TS_OFF, "table write outside the table")
    `I2CW_ASSERT_NEXT(a_flags_sticky, i_clk, i_rst_n, 1'b1, (r_flags & $past(r_flags)) == $past(r_flags), "sticky flag cleared")
endmodule
`default_nettype wire

/* hdl/i2cw_out_stage.sv */
`default_nettype none
`include "i2c_slave_register_window_core_macros.svh"
module i2cw_out_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire i2cw_pkg::t_res_info         i_info,
    input  wire logic [i2cw_pkg::BYTE_W-1:0] i_rd_data,
    output logic                             o_in_ready,
    i2cw_res_if.source                       o_res
);
    import i2cw_pkg::*;

    logic              r_s1_valid;
    t_res_info         r_s1;
    logic              r_o_valid;
    logic              r_o_tx_valid;
    logic [BYTE_W-1:0] r_o_tx_byte;
    logic              r_o_dir_send;
    logic [FLAG_W-1:0] r_o_flags;
    logic              move;
    logic [BYTE_W-1:0] s1_byte;

    assign move       = r_s1_valid && (!r_o_valid || o_res.ready);
    assign o_in_ready = !r_s1_valid || move;

    always_comb begin
        case (r_s1.src)
            SRC_TABLE:      s1_byte = i_rd_data;
            SRC_OUT_RANGE:  s1_byte = BYTE_OUT_RANGE;
            SRC_OTHER_BASE: s1_byte = BYTE_OTHER_BASE;
            default:        s1_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_info;
        end
        if (move) begin
            r_o_tx_valid <= (r_s1.src != SRC_NONE);
            r_o_tx_byte  <= s1_byte;
            r_o_dir_send <= r_s1.dir_send;
            r_o_flags    <= r_s1.flags;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.tx_valid   = r_o_tx_valid;
    assign o_res.tx_byte    = r_o_tx_byte;
    assign o_res.dir_send   = r_o_dir_send;
    assign o_res.read_done  = r_o_flags[FLAG_READ];
    assign o_res.write_done = r_o_flags[FLAG_WRITE];
    assign o_res.nack_seen  = r_o_flags[FLAG_NACK];
    assign o_res.error_seen = r_o_flags[FLAG_ERROR];

    `I2CW_ASSERT_NOW(a_full_stall_blocks_input, i_clk, i_rst_n, r_s1_valid && r_o_valid && !o_res.ready, !o_in_ready, "input taken while both stages are held")
    `I2CW_ASSERT_NEXT(a_move_fills_output, i_clk, i_rst_n, move, r_o_valid, "item lost between stages")
    `I2CW_ASSERT_NEXT(a_load_fills_stage, i_clk, i_rst_n, i_load, r_s1_valid, "accepted item not held")
endmodule
`default_nettype wire

/* hdl/i2c_slave_register_window_core.sv */
`default_nettype none
// Slave side of an I2C register window. A new event item may be taken before the result of the
// last has left, whenever ready is high; each result passes through the table memory's registered
// read and the output register. Ready falls only when an item waits in the read stage while the
// output register is held by the sink. The byte table lives in a synchronous memory with one
// write port and one read port; per-entry written bits cleared by reset make unwritten entries
// read as zero, so no clearing pass is needed. no_stretch resets to 1 and is written through
// i_cfg_we/i_cfg_wdata; the user must write it only while the block is idle (not enforced).
module i2c_slave_register_window_core #(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    i2cw_evt_if.sink   i_evt,
    i2cw_res_if.source o_res
);
    import i2cw_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    t_evt              evt;
    t_res_info         info;
    logic              accept;
    logic              in_ready;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_data;

    assign evt.addr_match = i_evt.addr_match;
    assign evt.dir_read   = i_evt.dir_read;
    assign evt.tx_request = i_evt.tx_request;
    assign evt.rx_valid   = i_evt.rx_valid;
    assign evt.rx_byte    = i_evt.rx_byte;
    assign evt.nack_event = i_evt.nack_event;
    assign evt.stop_event = i_evt.stop_event;
    assign evt.bus_error  = i_evt.bus_error;
    assign evt.arb_lost   = i_evt.arb_lost;
    assign evt.overrun    = i_evt.overrun;

    assign i_evt.ready = in_ready;
    assign accept      = i_evt.valid && in_ready;

    i2cw_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_evt       (evt),
        .o_info      (info),
        .o_rd_en     (rd_en),
        .o_rd_idx    (rd_idx),
        .o_wr_en     (wr_en),
        .o_wr_idx    (wr_idx),
        .o_wr_data   (wr_data)
    );

    i2cw_table_mem #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_table_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    i2cw_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_info     (info),
        .i_rd_data  (rd_data),
        .o_in_ready (in_ready),
        .o_res      (o_res)
    );
endmodule
`default_nettype wire
